@@ sv/flf_pkg.sv @@
// Shared constants and types for the line FIR filter.
// Used by the channel interfaces, the MAC pipeline, the top level and the checker.
`timescale 1ns / 1ps

package flf_pkg;

	localparam int MAX_TAPS       = 16;
	localparam int IDX_W          = $clog2(MAX_TAPS);
	localparam int TAP_W          = 5;
	localparam int DATA_W         = 16;
	localparam int SAMPLE_W       = DATA_W + 1;
	localparam int COEF_W         = 16;
	localparam int COEF_FRAC_BITS = 14;
	localparam int MAX_LINE       = 4096;
	localparam int LINE_W         = 13;
	localparam int POS_W          = 13;
	localparam int X_W            = POS_W + 3;
	localparam int CFG_W          = 64;
	localparam int CFG_IDX_W      = 3;
	localparam int COEF_GROUPS    = 4;
	localparam int COEFS_PER_GRP  = MAX_TAPS / COEF_GROUPS;
	localparam int PROD_W         = COEF_W + SAMPLE_W;
	localparam int PART_W         = PROD_W + $clog2(COEFS_PER_GRP);
	localparam int ACC_W          = PART_W + $clog2(COEF_GROUPS);
	localparam int TRUNC_W        = ACC_W - COEF_FRAC_BITS;

	localparam int SIGNED_LO   = -(2 ** (DATA_W - 1));
	localparam int SIGNED_HI   = 2 ** (DATA_W - 1) - 1;
	localparam int UNSIGNED_HI = 2 ** DATA_W - 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TAP_COUNT,
		REG_CENTER_OFFSET,
		REG_LINE_LENGTH,
		REG_SAMPLE_SIGNED,
		REG_COEF_A,
		REG_COEF_B,
		REG_COEF_C,
		REG_COEF_D
	} cfg_reg_t;

	typedef logic [MAX_TAPS-1:0][SAMPLE_W-1:0] lane_ops_t;
	typedef logic [MAX_TAPS-1:0][COEF_W-1:0]   lane_coefs_t;

	// Side information that travels with one product set through the pipeline.
	typedef struct packed {
		logic line_done;
		logic sample_signed;
	} flf_tag_t;

endpackage

@@ sv/flf_in_if.sv @@
// Input channel of the line FIR filter: valid/ready handshake with one sample per word.
// Depends on flf_pkg for the sample width.
`timescale 1ns / 1ps

interface flf_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [flf_pkg::SAMPLE_W-1:0]  sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
	modport monitor (input valid, input sample, input ready);
endinterface

@@ sv/flf_out_if.sv @@
// Result channel of the line FIR filter: valid/ready handshake with one filtered sample.
// Depends on flf_pkg for the sample width.
`timescale 1ns / 1ps

interface flf_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [flf_pkg::SAMPLE_W-1:0]  filtered;
	logic                                 clipped;
	logic                                 line_done;

	modport source (output valid, output filtered, output clipped, output line_done,
		input ready);
	modport sink (input valid, input filtered, input clipped, input line_done,
		output ready);
	modport monitor (input valid, input filtered, input clipped, input line_done,
		input ready);
endinterface

@@ sv/flf_mac.sv @@
// Elastic multiply-accumulate pipeline: operands, products, partial sums, total,
// then truncation and saturation into the result register. Depends on flf_pkg, flf_out_if.
`timescale 1ns / 1ps

module flf_mac (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  flf_pkg::lane_ops_t   ops,
	input  flf_pkg::lane_coefs_t coefs,
	input  flf_pkg::flf_tag_t    tag,
	output logic                 ready,
	flf_out_if.source            res
);

	logic v_s1, v_s2, v_s3, v_s4, v_q;
	logic go1, go2, go3, go4, go_out;

	logic signed [flf_pkg::SAMPLE_W-1:0] op_s1   [flf_pkg::MAX_TAPS];
	logic signed [flf_pkg::PROD_W-1:0]   prod_s2 [flf_pkg::MAX_TAPS];
	logic signed [flf_pkg::PART_W-1:0]   part_s3 [flf_pkg::COEF_GROUPS];
	logic signed [flf_pkg::ACC_W-1:0]    acc_s4;
	flf_pkg::flf_tag_t tag_s1, tag_s2, tag_s3, tag_s4;

	logic signed [flf_pkg::PART_W-1:0]   part_sum [flf_pkg::COEF_GROUPS];
	logic signed [flf_pkg::ACC_W-1:0]    acc_sum;
	logic signed [flf_pkg::TRUNC_W-1:0]  trunc_val, lo, hi, sat_val;
	logic                                clip;

	logic signed [flf_pkg::SAMPLE_W-1:0] filtered_q;
	logic                                clipped_q, line_done_q;

	// A stage moves on when it is empty or the stage after it moves on.
	assign go_out = !v_q || res.ready;
	assign go4    = !v_s4 || go_out;
	assign go3    = !v_s3 || go4;
	assign go2    = !v_s2 || go3;
	assign go1    = !v_s1 || go2;
	assign ready  = go1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (go1)    v_s1 <= load;
			if (go2)    v_s2 <= v_s1;
			if (go3)    v_s3 <= v_s2;
			if (go4)    v_s4 <= v_s3;
			if (go_out) v_q  <= v_s4;
		end
	end

	always_comb begin
		for (int g = 0; g < flf_pkg::COEF_GROUPS; g++) begin
			part_sum[g] = '0;
			for (int k = 0; k < flf_pkg::COEFS_PER_GRP; k++) begin
				part_sum[g] = part_sum[g]
					+ flf_pkg::PART_W'(prod_s2[g * flf_pkg::COEFS_PER_GRP + k]);
			end
		end
		acc_sum = '0;
		for (int g = 0; g < flf_pkg::COEF_GROUPS; g++) begin
			acc_sum = acc_sum + flf_pkg::ACC_W'(part_s3[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (go1) begin
			for (int i = 0; i < flf_pkg::MAX_TAPS; i++) begin
				op_s1[i] <= $signed(ops[i]);
			end
			tag_s1 <= tag;
		end
		// The user must rewrite coefficients only while the pipeline is empty; the block itself does not enforce it.
		if (go2) begin
			for (int i = 0; i < flf_pkg::MAX_TAPS; i++) begin
				prod_s2[i] <= $signed(coefs[i]) * op_s1[i];
			end
			tag_s2 <= tag_s1;
		end
		if (go3) begin
			for (int g = 0; g < flf_pkg::COEF_GROUPS; g++) begin
				part_s3[g] <= part_sum[g];
			end
			tag_s3 <= tag_s2;
		end
		if (go4) begin
			acc_s4 <= acc_sum;
			tag_s4 <= tag_s3;
		end
	end

	// Truncate toward zero: floor shift, then step up negative values with a fraction.
	always_comb begin
		trunc_val = acc_s4[flf_pkg::ACC_W-1:flf_pkg::COEF_FRAC_BITS]
			+ flf_pkg::TRUNC_W'(acc_s4[flf_pkg::ACC_W-1]
			&& (|acc_s4[flf_pkg::COEF_FRAC_BITS-1:0]));
		lo = tag_s4.sample_signed ? flf_pkg::TRUNC_W'(flf_pkg::SIGNED_LO) : '0;
		hi = tag_s4.sample_signed ? flf_pkg::TRUNC_W'(flf_pkg::SIGNED_HI)
			: flf_pkg::TRUNC_W'(flf_pkg::UNSIGNED_HI);
		clip    = 1'b0;
		sat_val = trunc_val;
		if (trunc_val < lo) begin
			sat_val = lo;
			clip    = 1'b1;
		end
		if (trunc_val > hi) begin
			sat_val = hi;
			clip    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (go_out) begin
			filtered_q  <= sat_val[flf_pkg::SAMPLE_W-1:0];
			clipped_q   <= clip;
			line_done_q <= tag_s4.line_done;
		end
	end

	assign res.valid     = v_q;
	assign res.filtered  = filtered_q;
	assign res.clipped   = clipped_q;
	assign res.line_done = line_done_q;

endmodule

@@ sv/fir_line_filter.sv @@
// A sample that completes an output passes the operand, product, partial-sum, total and result registers of flf_mac.
// Throughput: one sample per cycle unless the result side stalls; the 16 taps are multiplied in parallel in flf_mac.
// Border samples that complete no output are taken even while the result side stalls.
// Reset: registers return to their reset values, the window clears to zero,
// the line position returns to zero and the pipeline empties.
// Depends on flf_pkg, flf_in_if, flf_out_if and flf_mac.
`timescale 1ns / 1ps

module fir_line_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [flf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [flf_pkg::CFG_W-1:0]       cfg_data,
	flf_in_if.sink                          pix,
	flf_out_if.source                       res
);

	logic [flf_pkg::TAP_W-1:0]  tap_count_q, center_q;
	logic [flf_pkg::LINE_W-1:0] line_length_q;
	logic                       sample_signed_q;
	logic [flf_pkg::COEF_GROUPS-1:0][flf_pkg::CFG_W-1:0] coef_grp_q;

	logic signed [flf_pkg::SAMPLE_W-1:0] window_q [flf_pkg::MAX_TAPS];
	logic signed [flf_pkg::SAMPLE_W-1:0] win_new  [flf_pkg::MAX_TAPS];
	logic [flf_pkg::POS_W-1:0]           pos_q;

	logic [flf_pkg::TAP_W-1:0]    taps, cen;
	logic [flf_pkg::LINE_W-1:0]   len, len_m1;
	logic [flf_pkg::LINE_W:0]     total;
	logic [flf_pkg::POS_W:0]      pos_inc;
	logic signed [flf_pkg::X_W-1:0] xs;
	logic hit, last, accept, mac_ready;
	logic signed [flf_pkg::SAMPLE_W-1:0] s_new;

	flf_pkg::lane_ops_t   ops;
	flf_pkg::lane_coefs_t coefs;
	flf_pkg::flf_tag_t    tag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q     <= flf_pkg::TAP_W'(1);
			center_q        <= '0;
			line_length_q   <= flf_pkg::LINE_W'(flf_pkg::MAX_LINE);
			sample_signed_q <= 1'b1;
			coef_grp_q      <= '0;
		end else if (cfg_we) begin
			case (flf_pkg::cfg_reg_t'(cfg_index))
				flf_pkg::REG_TAP_COUNT:     tap_count_q     <= cfg_data[flf_pkg::TAP_W-1:0];
				flf_pkg::REG_CENTER_OFFSET: center_q        <= cfg_data[flf_pkg::TAP_W-1:0];
				flf_pkg::REG_LINE_LENGTH:   line_length_q   <= cfg_data[flf_pkg::LINE_W-1:0];
				flf_pkg::REG_SAMPLE_SIGNED: sample_signed_q <= cfg_data[0];
				flf_pkg::REG_COEF_A:        coef_grp_q[0]   <= cfg_data;
				flf_pkg::REG_COEF_B:        coef_grp_q[1]   <= cfg_data;
				flf_pkg::REG_COEF_C:        coef_grp_q[2]   <= cfg_data;
				flf_pkg::REG_COEF_D:        coef_grp_q[3]   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Out-of-range settings are clamped here rather than at write time.
	always_comb begin
		if (tap_count_q == '0) begin
			taps = flf_pkg::TAP_W'(1);
		end else if (tap_count_q > flf_pkg::TAP_W'(flf_pkg::MAX_TAPS)) begin
			taps = flf_pkg::TAP_W'(flf_pkg::MAX_TAPS);
		end else begin
			taps = tap_count_q;
		end
		cen = (center_q > taps) ? taps : center_q;
		if (line_length_q == '0) begin
			len = flf_pkg::LINE_W'(1);
		end else if (line_length_q > flf_pkg::LINE_W'(flf_pkg::MAX_LINE)) begin
			len = flf_pkg::LINE_W'(flf_pkg::MAX_LINE);
		end else begin
			len = line_length_q;
		end
		len_m1  = len - 1'b1;
		total   = {1'b0, len} + (flf_pkg::LINE_W + 1)'({taps, 1'b0});
		pos_inc = {1'b0, pos_q} + 1'b1;
		xs = $signed(flf_pkg::X_W'(pos_inc)) + $signed(flf_pkg::X_W'(cen))
			- $signed(flf_pkg::X_W'({taps, 1'b0}));
		hit  = !xs[flf_pkg::X_W-1] && (xs < $signed(flf_pkg::X_W'(len)));
		last = (xs == $signed(flf_pkg::X_W'(len_m1)));
	end

	assign s_new = sample_signed_q ? {pix.sample[flf_pkg::DATA_W-1], pix.sample[flf_pkg::DATA_W-1:0]}
		: {1'b0, pix.sample[flf_pkg::DATA_W-1:0]};

	// A sample that completes no output never needs a pipeline slot.
	assign pix.ready = !hit || mac_ready;
	assign accept    = pix.valid && pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < flf_pkg::MAX_TAPS; i++) begin
				window_q[i] <= '0;
			end
			pos_q <= '0;
		end else if (accept) begin
			for (int i = 0; i < flf_pkg::MAX_TAPS; i++) begin
				window_q[i] <= win_new[i];
			end
			pos_q <= (pos_inc >= total) ? '0 : pos_inc[flf_pkg::POS_W-1:0];
		end
	end

	// Lane i multiplies coefficient i with the sample taps-1-i places back.
	for (genvar i = 0; i < flf_pkg::MAX_TAPS; i++) begin : g_lane
		localparam logic [flf_pkg::TAP_W-1:0] LANE = flf_pkg::TAP_W'(i);
		logic [flf_pkg::TAP_W-1:0] back;

		if (i == 0) begin : g_first
			assign win_new[i] = s_new;
		end else begin : g_rest
			assign win_new[i] = window_q[i-1];
		end

		assign back   = taps - LANE - 1'b1;
		assign ops[i] = (LANE < taps) ? win_new[back[flf_pkg::IDX_W-1:0]] : '0;
		assign coefs[i] = coef_grp_q[i / flf_pkg::COEFS_PER_GRP]
			[(i % flf_pkg::COEFS_PER_GRP) * flf_pkg::COEF_W +: flf_pkg::COEF_W];
	end

	assign tag.line_done     = last;
	assign tag.sample_signed = sample_signed_q;

	flf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept && hit),
		.ops    (ops),
		.coefs  (coefs),
		.tag    (tag),
		.ready  (mac_ready),
		.res    (res)
	);

endmodule

@@ sv/flf_checker.sv @@
// Port-level checks on the result channel of the line FIR filter, bound to the top level.
// Depends on flf_pkg; the bind connects the top level's result interface signals.
`timescale 1ns / 1ps

module flf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [flf_pkg::SAMPLE_W-1:0]  res_filtered,
	input logic                          res_clipped,
	input logic                          res_line_done
);

	// A stalled word holds until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_filtered)
			&& $stable(res_clipped) && $stable(res_line_done))
		else $error("result word changed while stalled");

	// A clipped word sits on one of the saturation bounds.
	a_clip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_clipped |->
			res_filtered == flf_pkg::SAMPLE_W'(flf_pkg::SIGNED_LO)
			|| res_filtered == flf_pkg::SAMPLE_W'(flf_pkg::SIGNED_HI)
			|| res_filtered == '0
			|| res_filtered == flf_pkg::SAMPLE_W'(flf_pkg::UNSIGNED_HI))
		else $error("clipped word is not at a bound");

	// No word falls below the signed sample minimum.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_filtered[flf_pkg::SAMPLE_W-1]
			&& !res_filtered[flf_pkg::SAMPLE_W-2]))
		else $error("filtered word out of sample range");

endmodule

bind fir_line_filter flf_checker u_flf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_filtered  (res.filtered),
	.res_clipped   (res.clipped),
	.res_line_done (res.line_done)
);

@@ test/fir_line_filter_test.sv @@
// Self-checking bench for fir_line_filter: drives border-extended lines, predicts every filtered word.
// Depends on flf_pkg, flf_in_if, flf_out_if and the fir_line_filter top level.
`timescale 1ns / 1ps

module fir_line_filter_test;

	localparam int SAMPLE_W       = flf_pkg::SAMPLE_W;
	localparam int DATA_W         = flf_pkg::DATA_W;
	localparam int TAP_W          = flf_pkg::TAP_W;
	localparam int LINE_W         = flf_pkg::LINE_W;
	localparam int CFG_W          = flf_pkg::CFG_W;
	localparam int CFG_IDX_W      = flf_pkg::CFG_IDX_W;
	localparam int COEF_W         = flf_pkg::COEF_W;
	localparam int COEF_GROUPS    = flf_pkg::COEF_GROUPS;
	localparam int COEFS_PER_GRP  = flf_pkg::COEFS_PER_GRP;
	localparam int COEF_FRAC_BITS = flf_pkg::COEF_FRAC_BITS;
	localparam int MAX_TAPS       = flf_pkg::MAX_TAPS;
	localparam int MAX_LINE       = flf_pkg::MAX_LINE;
	localparam int SIGNED_LO      = flf_pkg::SIGNED_LO;
	localparam int SIGNED_HI      = flf_pkg::SIGNED_HI;
	localparam int UNSIGNED_HI    = flf_pkg::UNSIGNED_HI;

	typedef flf_pkg::cfg_reg_t cfg_reg_t;

	localparam int LATENCY_WAIT = 12;
	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 40;
	localparam int FINAL_LINE   = 24;

	localparam int TAP_PICKS [PHASES]  = '{1, 16, 0, 31, 16, 5, 2, 9, 17, 4, 12, 7};
	localparam int LINE_PICKS [PHASES] = '{1, 5, 0, 8191, 4096, 3, 2, 10, 7, 40, 6, 12};

	typedef struct packed {
		logic [SAMPLE_W-1:0] filtered;
		logic                clipped;
		logic                line_done;
	} filtered_word_t;

	typedef struct packed {
		logic [TAP_W-1:0]                   taps;
		logic [TAP_W-1:0]                   center;
		logic [LINE_W-1:0]                  line_len;
		logic                               sgn;
		logic [COEF_GROUPS-1:0][CFG_W-1:0]  coefs;
	} filter_setup_t;

	// Tracks the filter's registers, window and line position, and the words still owed.
	class fir_line_ledger;
		logic [TAP_W-1:0]  tap_reg;
		logic [TAP_W-1:0]  center_reg;
		logic [LINE_W-1:0] line_reg;
		logic              signed_reg;
		logic [CFG_W-1:0]  coef_reg [COEF_GROUPS];
		int                window [MAX_TAPS];
		int                position;
		filtered_word_t    owed_words [$];
		int                errors;

		function new();
			tap_reg    = 1;
			center_reg = 0;
			line_reg   = LINE_W'(MAX_LINE);
			signed_reg = 1'b1;
			foreach (coef_reg[g]) coef_reg[g] = '0;
			foreach (window[i]) window[i] = 0;
			position = 0;
			errors   = 0;
		endfunction

		function void set_reg(cfg_reg_t r, logic [CFG_W-1:0] d);
			case (r)
				flf_pkg::REG_TAP_COUNT:     tap_reg = d[TAP_W-1:0];
				flf_pkg::REG_CENTER_OFFSET: center_reg = d[TAP_W-1:0];
				flf_pkg::REG_LINE_LENGTH:   line_reg = d[LINE_W-1:0];
				flf_pkg::REG_SAMPLE_SIGNED: signed_reg = d[0];
				flf_pkg::REG_COEF_A:        coef_reg[0] = d;
				flf_pkg::REG_COEF_B:        coef_reg[1] = d;
				flf_pkg::REG_COEF_C:        coef_reg[2] = d;
				flf_pkg::REG_COEF_D:        coef_reg[3] = d;
				default: ;
			endcase
		endfunction

		function int pending();
			return owed_words.size();
		endfunction

		function void take_sample(logic [SAMPLE_W-1:0] raw);
			int                       taps, cen, len, total, x;
			longint                   acc, lo, hi;
			logic signed [COEF_W-1:0] c;
			filtered_word_t           w;
			taps = tap_reg;
			if (taps < 1) taps = 1;
			if (taps > MAX_TAPS) taps = MAX_TAPS;
			cen = center_reg;
			if (cen > taps) cen = taps;
			len = line_reg;
			if (len < 1) len = 1;
			if (len > MAX_LINE) len = MAX_LINE;
			total = len + 2 * taps;

			for (int i = MAX_TAPS - 1; i > 0; i--) window[i] = window[i-1];
			window[0] = signed_reg ? int'($signed(raw[DATA_W-1:0]))
				: int'({1'b0, raw[DATA_W-1:0]});

			x = position - 2 * taps + 1 + cen;
			if (x >= 0 && x < len) begin
				acc = 0;
				for (int i = 0; i < taps; i++) begin
					c = coef_reg[i / COEFS_PER_GRP][(i % COEFS_PER_GRP) * COEF_W +: COEF_W];
					acc += longint'(c) * longint'(window[taps - 1 - i]);
				end
				// Signed division rounds toward zero, which is the truncation wanted here.
				acc = acc / (longint'(1) << COEF_FRAC_BITS);
				lo = signed_reg ? SIGNED_LO : 0;
				hi = signed_reg ? SIGNED_HI : UNSIGNED_HI;
				w.clipped = 1'b0;
				if (acc < lo) begin
					acc = lo;
					w.clipped = 1'b1;
				end
				if (acc > hi) begin
					acc = hi;
					w.clipped = 1'b1;
				end
				w.filtered  = SAMPLE_W'(acc);
				w.line_done = (x == len - 1);
				owed_words.push_back(w);
			end
			position = (position + 1 >= total) ? 0 : position + 1;
		endfunction

		function void check_filtered(logic [SAMPLE_W-1:0] got_value, logic got_clip,
			logic got_done);
			filtered_word_t w;
			if (owed_words.size() == 0) begin
				errors++;
				$display("%0t: word with none expected, got %0d clip=%0b done=%0b",
					$time, $signed(got_value), got_clip, got_done);
			end else begin
				w = owed_words.pop_front();
				if (w.filtered !== got_value || w.clipped !== got_clip
					|| w.line_done !== got_done) begin
					errors++;
					$display("%0t: expected %0d clip=%0b done=%0b, got %0d clip=%0b done=%0b",
						$time, $signed(w.filtered), w.clipped, w.line_done,
						$signed(got_value), got_clip, got_done);
				end
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   send_idle_pct = 0;
	int                   recv_stall_pct = 0;
	int                   hold_left = 0;
	int                   quiet_cycles = 0;
	fir_line_ledger       book = new();

	flf_in_if  pix();
	flf_out_if res();

	fir_line_filter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix       (pix),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && pix.valid && pix.ready) book.take_sample(pix.sample);
		if (arst_n && res.valid && res.ready)
			book.check_filtered(res.filtered, res.clipped, res.line_done);
		if (arst_n && cfg_we) book.set_reg(cfg_reg_t'(cfg_index), cfg_data);
	end

	always @(posedge clk) begin
		if ((pix.valid && pix.ready) || (res.valid && res.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("fir_line_filter: mismatch");
			$finish;
		end
	end

	// Result side: a long hold-off when asked, random stalls otherwise.
	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(15))
			0: return 17'h18000;
			1: return 17'h07FFF;
			2: return 17'h0FFFF;
			3: return SAMPLE_W'($urandom);
			default: return SAMPLE_W'(int'($urandom_range(98303)) - 32768);
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_sample(input logic [SAMPLE_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			pix.valid <= 1'b0;
			@(negedge clk);
		end
		pix.valid  <= 1'b1;
		pix.sample <= value;
		do @(posedge clk); while (!pix.ready);
		@(negedge clk);
	endtask

	task automatic settle();
		pix.valid <= 1'b0;
		while (book.pending() != 0) @(negedge clk);
		repeat (LATENCY_WAIT) @(negedge clk);
	endtask

	task automatic apply_config(input filter_setup_t s);
		logic [CFG_W-1:0] junk;
		for (int r = flf_pkg::REG_TAP_COUNT; r <= flf_pkg::REG_COEF_D; r++) begin
			// Upper bits of the narrow registers carry noise; only the low bits count.
			junk = {$urandom, $urandom};
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(r);
			case (cfg_reg_t'(r))
				flf_pkg::REG_TAP_COUNT:     cfg_data <= {junk[CFG_W-1:TAP_W], s.taps};
				flf_pkg::REG_CENTER_OFFSET: cfg_data <= {junk[CFG_W-1:TAP_W], s.center};
				flf_pkg::REG_LINE_LENGTH:   cfg_data <= {junk[CFG_W-1:LINE_W], s.line_len};
				flf_pkg::REG_SAMPLE_SIGNED: cfg_data <= {junk[CFG_W-1:1], s.sgn};
				default:                    cfg_data <= s.coefs[r - flf_pkg::REG_COEF_A];
			endcase
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		filter_setup_t            setup;
		logic [SAMPLE_W-1:0]      edge_samples [11];
		logic signed [COEF_W-1:0] lane;
		bit                       wide_coefs;
		edge_samples = '{17'h18000, 17'h07FFF, 17'h0FFFF, 17'h10000, 17'h08000, 17'h1FFFF,
			17'h00000, 17'h0FFFF, 17'h07FFF, 17'h18000, 17'h00001};

		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = flf_pkg::REG_TAP_COUNT;
		cfg_data   = '0;
		pix.valid  = 1'b0;
		pix.sample = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: one tap, zero coefficients, full-length line.
		for (int n = 0; n < 3; n++) send_sample(rand_sample());
		settle();

		// Extreme coefficients with full-scale samples; centre above the tap count.
		setup.taps     = 4;
		setup.center   = 31;
		setup.line_len = 6;
		setup.sgn      = 1'b1;
		setup.coefs    = {{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{16'h4000, 16'hC000, 16'h7FFF, 16'h8000}};
		apply_config(setup);
		foreach (edge_samples[i]) send_sample(edge_samples[i]);
		settle();

		// Unsigned samples through all sixteen taps.
		setup.taps     = 16;
		setup.center   = 0;
		setup.line_len = 3;
		setup.sgn      = 1'b0;
		setup.coefs    = {{4{16'h8000}}, {4{16'h8000}}, {4{16'h7FFF}}, {4{16'h7FFF}}};
		apply_config(setup);
		foreach (edge_samples[i]) send_sample(edge_samples[i]);
		settle();

		for (int k = 0; k < PHASES; k++) begin
			setup.taps     = TAP_W'(TAP_PICKS[k]);
			setup.center   = (k == 3) ? 5'd31 : (k == 1) ? 5'd16 : TAP_W'($urandom_range(0, 17));
			setup.line_len = LINE_W'(LINE_PICKS[k]);
			setup.sgn      = $urandom_range(1);
			wide_coefs     = (k % 3 == 0);
			for (int i = 0; i < MAX_TAPS; i++) begin
				lane = wide_coefs ? COEF_W'($urandom) : COEF_W'(int'($urandom_range(8191)) - 4096);
				setup.coefs[i / COEFS_PER_GRP][(i % COEFS_PER_GRP) * COEF_W +: COEF_W] = lane;
			end
			apply_config(setup);
			case (k % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 75;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 75;
				end
				default: begin
					send_idle_pct  = 25;
					recv_stall_pct = 25;
				end
			endcase
			// The sender keeps offering while the result side is held off, filling the pipe.
			if (k == 4) hold_left = HOLD_CYCLES;
			for (int n = 0; n < PHASE_ITEMS; n++) send_sample(rand_sample());
			settle();
		end

		// One whole line at the largest tap count, so the line end is reached with every tap.
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		setup.taps     = 16;
		setup.center   = 8;
		setup.line_len = LINE_W'(FINAL_LINE);
		setup.sgn      = 1'b1;
		for (int i = 0; i < MAX_TAPS; i++)
			setup.coefs[i / COEFS_PER_GRP][(i % COEFS_PER_GRP) * COEF_W +: COEF_W] =
				COEF_W'(int'($urandom_range(4095)) - 2048);
		apply_config(setup);
		for (int n = 0; n < FINAL_LINE + 2 * MAX_TAPS; n++) send_sample(rand_sample());
		settle();

		if (book.errors == 0) begin
			$display("fir_line_filter: match");
		end else begin
			$display("fir_line_filter: mismatch");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/flf_pkg.sv
sv/flf_in_if.sv
sv/flf_out_if.sv
sv/flf_mac.sv
sv/fir_line_filter.sv
sv/flf_checker.sv
test/fir_line_filter_test.sv
